// ----- rtl/plf_pkg.sv -----
// Shared types, codes and constants of the priority least-failure round-robin picker.
package plf_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int NUM_PRIO_DEF  = 8;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 4;
  localparam int PRIO_IN_W  = 3;
  localparam int FAIL_W     = 8;
  localparam int CMP_W      = FAIL_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int OP_W       = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_FLOOR  = 2'd1;

  localparam logic [FAIL_W-1:0]    RETRIES_RST = 8'd3;
  localparam logic [FAIL_W-1:0]    FAIL_MAX    = 8'd255;
  localparam logic [PRIO_IN_W-1:0] FLOOR_RST   = 3'd0;
  localparam logic [CMP_W-1:0]     LEAST_INIT  = {1'b1, {FAIL_W{1'b0}}};

  localparam logic [OP_W-1:0] OP_MAX   = 2'd0;
  localparam logic [OP_W-1:0] OP_MIN   = 2'd1;
  localparam logic [OP_W-1:0] OP_PICK  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAN = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [IDX_W-1:0]     entry_index;
    logic [PRIO_IN_W-1:0] priority_req;
    logic                 success;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] selected_index;
    logic             pool_empty;
  } out_word_t;

  typedef struct packed {
    logic hit;
    logic above;
  } cmp_res_t;

endpackage

// ----- rtl/plf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module plf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/plf_cmp_unit.sv -----
// Shared compare unit used by every slot scan of the picker.
module plf_cmp_unit #(
  parameter int SLOT_W = $clog2(plf_pkg::NUM_SLOTS_DEF),
  parameter int PRIO_W = $clog2(plf_pkg::NUM_PRIO_DEF)
) (
  input  logic [plf_pkg::OP_W-1:0]   op,
  input  logic                       ent_valid,
  input  logic [PRIO_W-1:0]          ent_prio,
  input  logic [plf_pkg::FAIL_W-1:0] ent_fail,
  input  logic [SLOT_W-1:0]          ent_idx,
  input  logic [PRIO_W-1:0]          top,
  input  logic [plf_pkg::CMP_W-1:0]  least,
  input  logic [SLOT_W-1:0]          last,
  input  logic [plf_pkg::FAIL_W-1:0] retry_limit,
  output plf_pkg::cmp_res_t          res
);

  import plf_pkg::*;

  logic [CMP_W-1:0] opa;
  logic [CMP_W-1:0] opb;
  logic             gt;
  logic             prio_eq;
  logic             fail_eq;

  always_comb begin
    unique case (op)
      OP_MAX: begin
        opa = CMP_W'(ent_prio);
        opb = CMP_W'(top);
      end
      OP_MIN: begin
        opa = least;
        opb = CMP_W'(ent_fail);
      end
      OP_PICK: begin
        opa = CMP_W'(ent_idx);
        opb = CMP_W'(last);
      end
      default: begin
        opa = CMP_W'(ent_fail);
        opb = CMP_W'(retry_limit);
      end
    endcase
  end

  assign gt      = opa > opb;
  assign prio_eq = ent_prio == top;
  assign fail_eq = CMP_W'(ent_fail) == least;

  always_comb begin
    res.above = gt;
    unique case (op)
      OP_MAX:  res.hit = ent_valid && gt;
      OP_MIN:  res.hit = ent_valid && prio_eq && gt;
      OP_PICK: res.hit = ent_valid && prio_eq && fail_eq;
      default: res.hit = ent_valid && gt;
    endcase
  end

endmodule

// ----- rtl/priority_least_failure_rr_picker.sv -----
// Top level of the priority least-failure round-robin picker.
// Usage: one input word per command on in_valid/in_ready (load a slot, request
// a grant, report an outcome); exactly one result word per input on
// out_valid/out_ready; register writes on cfg_valid/cfg_ready, index 0 is
// the retry limit and index 1 is priority_floor, taken at any cycle.
// Slot priority and failure count live in one RAM that a single compare unit
// walks one slot per cycle. After acceptance, load and unused command go
// straight to the result, report does a read-modify-write and then one
// cleanup scan, and request runs the top priority, least failures and pick
// scans. in_ready is high only while no command is in work, so a new word
// can enter in the cycle after the previous result is registered.
// A result waits in the output register while out_ready is low; the next word
// is still taken and runs until its own result needs the register.
// Reset clears all slot valid bits, the last-granted table and the output
// valid, and loads a retry limit of 3 and priority_floor 0.
module priority_least_failure_rr_picker #(
  parameter int NUM_SLOTS      = plf_pkg::NUM_SLOTS_DEF,
  parameter int NUM_PRIORITIES = plf_pkg::NUM_PRIO_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  plf_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output plf_pkg::out_word_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [plf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [plf_pkg::CFG_DATA_W-1:0] cfg_data
);

  import plf_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int PRIO_W = $clog2(NUM_PRIORITIES);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int ENT_W  = PRIO_W + FAIL_W;

  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(NUM_SLOTS);
  localparam logic [PRIO_W-1:0] PRIO_TOP = PRIO_W'(NUM_PRIORITIES - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAX    = 3'd1;
  localparam logic [2:0] S_MIN    = 3'd2;
  localparam logic [2:0] S_PICK   = 3'd3;
  localparam logic [2:0] S_RPT_WR = 3'd4;
  localparam logic [2:0] S_CLEAN  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]             state_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [NUM_SLOTS-1:0]   valid_r;
  logic [SLOT_W-1:0]      last_g_r [NUM_PRIORITIES];
  logic [FAIL_W-1:0]      retry_limit_r;
  logic [PRIO_IN_W-1:0]   floor_r;
  logic                   out_valid_r;
  out_word_t              out_data_r;
  logic                   have_first_r;
  logic                   have_pick_r;
  logic                   found_r;
  logic [IDX_W-1:0]       rpt_idx_r;
  logic                   success_r;
  logic [PRIO_W-1:0]      top_r;
  logic [CMP_W-1:0]       least_r;
  logic [SLOT_W-1:0]      first_r;
  logic [SLOT_W-1:0]      pick_r;
  logic [SLOT_W-1:0]      sel_r;

  logic                   in_fire;
  logic [SLOT_W-1:0]      in_slot;
  logic                   in_idx_ok;
  logic [PRIO_W-1:0]      in_prio;
  logic [SLOT_W-1:0]      rpt_slot;
  logic                   rpt_idx_ok;
  logic [PRIO_W-1:0]      floor_clamp;
  logic [SLOT_W-1:0]      scan_pidx;
  logic                   scan_end;
  logic                   ent_valid;
  logic [ENT_W-1:0]       rd_data;
  logic [PRIO_W-1:0]      rd_prio;
  logic [FAIL_W-1:0]      rd_fail;
  logic [FAIL_W-1:0]      new_fail;
  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [ENT_W-1:0]       ram_wdata;
  logic [SLOT_W-1:0]      ram_raddr;
  logic [OP_W-1:0]        op;
  cmp_res_t               cmp;
  logic                   first_any;
  logic [SLOT_W-1:0]      grant_idx;
  logic                   out_free;

  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign in_slot     = SLOT_W'(in_data.entry_index);
  assign in_idx_ok   = 32'(in_data.entry_index) < NUM_SLOTS;
  assign in_prio     = (32'(in_data.priority_req) >= NUM_PRIORITIES) ? PRIO_TOP
                                                                     : PRIO_W'(in_data.priority_req);
  assign rpt_slot    = SLOT_W'(rpt_idx_r);
  assign rpt_idx_ok  = 32'(rpt_idx_r) < NUM_SLOTS;
  assign floor_clamp = (32'(floor_r) >= NUM_PRIORITIES) ? PRIO_TOP : PRIO_W'(floor_r);

  assign scan_pidx = SLOT_W'(cnt_r - 1'b1);
  assign scan_end  = cnt_r == CNT_LAST;
  assign ent_valid = (cnt_r != '0) && valid_r[scan_pidx];
  assign rd_prio   = rd_data[ENT_W-1:FAIL_W];
  assign rd_fail   = rd_data[FAIL_W-1:0];
  assign new_fail  = success_r ? '0 : ((rd_fail == FAIL_MAX) ? rd_fail : rd_fail + 1'b1);

  assign ram_we    = (in_fire && in_data.command == CMD_LOAD && in_idx_ok) ||
                     (state_r == S_RPT_WR && rpt_idx_ok && valid_r[rpt_slot]);
  assign ram_waddr = (state_r == S_IDLE) ? in_slot : rpt_slot;
  assign ram_wdata = (state_r == S_IDLE) ? {in_prio, {FAIL_W{1'b0}}} : {rd_prio, new_fail};
  assign ram_raddr = (state_r == S_IDLE) ? in_slot
                                         : ((cnt_r < CNT_LAST) ? SLOT_W'(cnt_r) : '0);

  always_comb begin
    unique case (state_r)
      S_MAX:   op = OP_MAX;
      S_MIN:   op = OP_MIN;
      S_PICK:  op = OP_PICK;
      default: op = OP_CLEAN;
    endcase
  end

  assign first_any = have_first_r || cmp.hit;
  always_comb begin
    if (have_pick_r) begin
      grant_idx = pick_r;
    end else if (cmp.hit && cmp.above) begin
      grant_idx = scan_pidx;
    end else if (have_first_r) begin
      grant_idx = first_r;
    end else begin
      grant_idx = scan_pidx;
    end
  end

  plf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  plf_cmp_unit #(
    .SLOT_W (SLOT_W),
    .PRIO_W (PRIO_W)
  ) u_cmp (
    .op          (op),
    .ent_valid   (ent_valid),
    .ent_prio    (rd_prio),
    .ent_fail    (rd_fail),
    .ent_idx     (scan_pidx),
    .top         (top_r),
    .least       (least_r),
    .last        (last_g_r[top_r]),
    .retry_limit (retry_limit_r),
    .res         (cmp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      valid_r       <= '0;
      retry_limit_r <= RETRIES_RST;
      floor_r       <= FLOOR_RST;
      out_valid_r   <= 1'b0;
      have_first_r  <= 1'b0;
      have_pick_r   <= 1'b0;
      found_r       <= 1'b0;
      for (int p = 0; p < NUM_PRIORITIES; p++) begin
        last_g_r[p] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_RETRY_LIMIT: retry_limit_r <= cfg_data[FAIL_W-1:0];
          CFG_PRIO_FLOOR:  floor_r <= cfg_data[PRIO_IN_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            found_r <= 1'b0;
            cnt_r   <= '0;
            unique case (in_data.command)
              CMD_LOAD: begin
                if (in_idx_ok) begin
                  valid_r[in_slot] <= 1'b1;
                end
                state_r <= S_DONE;
              end
              CMD_REQUEST: state_r <= S_MAX;
              CMD_REPORT:  state_r <= S_RPT_WR;
              default:     state_r <= S_DONE;
            endcase
          end
        end
        S_MAX: begin
          cnt_r <= scan_end ? '0 : cnt_r + 1'b1;
          if (scan_end) begin
            state_r <= S_MIN;
          end
        end
        S_MIN: begin
          cnt_r <= scan_end ? '0 : cnt_r + 1'b1;
          if (scan_end) begin
            have_first_r <= 1'b0;
            have_pick_r  <= 1'b0;
            state_r      <= S_PICK;
          end
        end
        S_PICK: begin
          cnt_r <= scan_end ? '0 : cnt_r + 1'b1;
          if (cmp.hit) begin
            have_first_r <= 1'b1;
            if (cmp.above) begin
              have_pick_r <= 1'b1;
            end
          end
          if (scan_end) begin
            state_r <= S_DONE;
            if (first_any) begin
              found_r           <= 1'b1;
              last_g_r[top_r]   <= grant_idx;
            end
          end
        end
        S_RPT_WR: begin
          state_r <= S_CLEAN;
        end
        S_CLEAN: begin
          cnt_r <= scan_end ? '0 : cnt_r + 1'b1;
          if (cmp.hit) begin
            valid_r[scan_pidx] <= 1'b0;
          end
          if (scan_end) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rpt_idx_r <= in_data.entry_index;
      success_r <= in_data.success;
      top_r     <= floor_clamp;
      least_r   <= LEAST_INIT;
    end
    if (state_r == S_MAX && cmp.hit) begin
      top_r <= rd_prio;
    end
    if (state_r == S_MIN && cmp.hit) begin
      least_r <= CMP_W'(rd_fail);
    end
    if (state_r == S_PICK) begin
      if (cmp.hit && !have_first_r) begin
        first_r <= scan_pidx;
      end
      if (cmp.hit && cmp.above && !have_pick_r) begin
        pick_r <= scan_pidx;
      end
      if (scan_end) begin
        sel_r <= grant_idx;
      end
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r.found          <= found_r;
      out_data_r.selected_index <= found_r ? IDX_W'(sel_r) : '0;
      out_data_r.pool_empty     <= ~|valid_r;
    end
  end

  a_sel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.selected_index == '0)
    else $error("result without grant carries a nonzero slot");

  a_grant_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> !out_data.pool_empty)
    else $error("grant reported with an empty pool");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("scan counter beyond table");

  a_load_sets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.command == CMD_LOAD && in_idx_ok |=> valid_r[$past(in_slot)])
    else $error("loaded slot not marked valid");

endmodule
